// File: sv/assert_macros.svh
// Assertion helpers for the run-set checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CHK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/ffs_pkg.sv
package ffs_pkg;

  localparam int CMD_W = 2;
  localparam int VAL_W = 13;
  localparam int ANS_W = 13;
  localparam int STS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

  localparam logic [STS_W-1:0] STS_DONE    = 2'd0;
  localparam logic [STS_W-1:0] STS_IGNORED = 2'd1;
  localparam logic [STS_W-1:0] STS_RANGE   = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ANS_ONE,
    OP_RANGE_ERR,
    OP_LEAF_ADDR,
    OP_SWEEP_INIT,
    OP_SWEEP,
    OP_ROOT_ADDR,
    OP_DUP,
    OP_LEAF_WR,
    OP_MERGE,
    OP_ROOT_SHORT,
    OP_Q_START,
    OP_DESCEND
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   rd_kids;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_query;
    logic k_zero;
    logic in_range;
    logic leaf_conflict;
    logic root_short;
    logic left_fit;
    logic cross_fit;
    logic half_one;
    logic at_root;
    logic sweep_last;
  } dp_stat_t;

endpackage

// File: sv/first_fit_free_run_set_unit.sv
// Channel   Ports                              Handshake
// input     in_command, in_value               start & !busy
// result    out_answer, out_status             out_valid, one cycle
//
// Insert/delete: leaf read and check, then per level a read of both children through
// the node RAM's two read ports and a merge-write; query: root read and check, then a
// read and evaluate step per level descended. Range errors, k of zero, duplicates and a
// root too short for k skip the tree walk. busy drops the cycle after the result.
// Reset and clear both sweep all 2*L-1 tree nodes, one a cycle (L is UNIVERSE
// rounded up to a power of two); busy stays high meanwhile.
// out_valid pulses for one cycle and cannot be held off.
module first_fit_free_run_set_unit import ffs_pkg::*; #(
  parameter int UNIVERSE = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CMD_W-1:0] in_command,
  input  logic [VAL_W-1:0] in_value,
  output logic             out_valid,
  output logic [ANS_W-1:0] out_answer,
  output logic [STS_W-1:0] out_status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ffs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  ffs_datapath #(.UNIVERSE(UNIVERSE)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_command (in_command),
    .in_value   (in_value),
    .stat       (stat),
    .answer     (out_answer),
    .status     (out_status)
  );

endmodule

// File: sv/ffs_ram.sv
module ffs_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// File: sv/ffs_datapath.sv
module ffs_datapath import ffs_pkg::*; #(
  parameter int UNIVERSE = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_cmd_t        cmd,
  input  logic [CMD_W-1:0] in_command,
  input  logic [VAL_W-1:0] in_value,
  output dp_stat_t         stat,
  output logic [ANS_W-1:0] answer,
  output logic [STS_W-1:0] status
);

  localparam int LW = $clog2(UNIVERSE);
  localparam int L  = 2 ** LW;
  localparam int NW = LW + 1;
  localparam int AW = LW + 1;
  localparam int DW = 3 * NW;

  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [NW-1:0]    span_r, span_nxt;
  logic [NW-1:0]    start_r, start_nxt;
  logic [ANS_W-1:0] ans_r, ans_nxt;
  logic [STS_W-1:0] sts_r, sts_nxt;

  logic          we;
  logic [DW-1:0] wdata;
  logic [AW-1:0] ra_addr, rb_addr;
  logic [DW-1:0] ra_data, rb_data;

  logic [NW-1:0] a_pre, a_suf, a_best, b_pre, b_suf, b_best;
  logic [NW-1:0] half, m_pre, m_suf, m_best, join_len, kid_best, leaf_v;
  logic [AW-1:0] idx_inc;
  logic [31:0]   k32;

  ffs_ram #(.WIDTH(DW), .DEPTH(2 * L)) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (idx_r),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

  assign ra_addr = cmd.rd_kids ? {idx_r[AW-2:0], 1'b0} : idx_r;
  assign rb_addr = {idx_r[AW-2:0], 1'b1};

  assign {a_pre, a_suf, a_best} = ra_data;
  assign {b_pre, b_suf, b_best} = rb_data;

  // merge uses child span; descent uses half of the current span
  assign half     = (cmd.op == OP_MERGE) ? span_r : (span_r >> 1);
  assign join_len = a_suf + b_pre;
  assign kid_best = (a_best > b_best) ? a_best : b_best;
  assign m_pre    = (a_pre == half) ? half + b_pre : a_pre;
  assign m_suf    = (b_suf == half) ? half + a_suf : b_suf;
  assign m_best   = (join_len > kid_best) ? join_len : kid_best;
  assign leaf_v   = (cmd_r == CMD_DELETE) ? NW'(1) : NW'(0);
  assign idx_inc  = idx_r + AW'(1);
  assign k32      = 32'(val_r);

  always_comb begin
    we    = 1'b0;
    wdata = {m_pre, m_suf, m_best};
    case (cmd.op)
      OP_SWEEP: begin
        we    = 1'b1;
        wdata = {span_r, span_r, span_r};
      end
      OP_LEAF_WR: begin
        we    = 1'b1;
        wdata = {leaf_v, leaf_v, leaf_v};
      end
      OP_MERGE: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_comb begin
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    span_nxt  = span_r;
    start_nxt = start_r;
    ans_nxt   = ans_r;
    sts_nxt   = sts_r;
    case (cmd.op)
      OP_LOAD: begin
        cmd_nxt = in_command;
        val_nxt = in_value;
        ans_nxt = '0;
        sts_nxt = STS_DONE;
      end
      OP_ANS_ONE:    ans_nxt = ANS_W'(1);
      OP_RANGE_ERR:  sts_nxt = STS_RANGE;
      OP_LEAF_ADDR:  idx_nxt = AW'(32'(L) + 32'(val_r) - 32'd1);
      OP_SWEEP_INIT: begin
        idx_nxt  = AW'(1);
        span_nxt = NW'(L);
      end
      OP_SWEEP: begin
        idx_nxt = idx_inc;
        if ((idx_inc & idx_r) == '0) begin
          span_nxt = span_r >> 1;
        end
      end
      OP_ROOT_ADDR: idx_nxt = AW'(1);
      OP_DUP:       sts_nxt = STS_IGNORED;
      OP_LEAF_WR: begin
        idx_nxt  = idx_r >> 1;
        span_nxt = NW'(1);
      end
      OP_MERGE: begin
        idx_nxt  = idx_r >> 1;
        span_nxt = span_r << 1;
      end
      OP_ROOT_SHORT: ans_nxt = ANS_W'(32'(L) - 32'(a_suf) + 32'd1);
      OP_Q_START: begin
        span_nxt  = NW'(L);
        start_nxt = NW'(1);
      end
      OP_DESCEND: begin
        span_nxt = half;
        if (32'(a_best) >= k32) begin
          idx_nxt = {idx_r[AW-2:0], 1'b0};
          ans_nxt = ANS_W'(start_r);
        end else if (32'(join_len) >= k32) begin
          ans_nxt = ANS_W'(32'(start_r) + 32'(half) - 32'(a_suf));
        end else begin
          idx_nxt   = {idx_r[AW-2:0], 1'b1};
          start_nxt = start_r + half;
          ans_nxt   = ANS_W'(32'(start_r) + 32'(half));
        end
      end
      default: cmd_nxt = cmd_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= AW'(1);
      span_r <= NW'(L);
    end else begin
      idx_r  <= idx_nxt;
      span_r <= span_nxt;
    end
    cmd_r   <= cmd_nxt;
    val_r   <= val_nxt;
    start_r <= start_nxt;
    ans_r   <= ans_nxt;
    sts_r   <= sts_nxt;
  end

  always_comb begin
    stat.is_clear      = (cmd_r == CMD_CLEAR);
    stat.is_query      = (cmd_r == CMD_QUERY);
    stat.k_zero        = (val_r == '0);
    stat.in_range      = (val_r != '0) && (32'(val_r) <= 32'(UNIVERSE));
    // leaf best of zero means the element is in the set
    stat.leaf_conflict = (cmd_r == CMD_INSERT) ? (a_best == '0) : (a_best != '0);
    stat.root_short    = (32'(a_best) < k32);
    stat.left_fit      = (32'(a_best) >= k32);
    stat.cross_fit     = (32'(join_len) >= k32);
    stat.half_one      = (half == NW'(1));
    stat.at_root       = (idx_r == AW'(1));
    stat.sweep_last    = (idx_r == AW'(2 * L - 1));
  end

  assign answer = ans_r;
  assign status = sts_r;

endmodule

// File: sv/ffs_ctrl.sv
module ffs_ctrl import ffs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  typedef enum logic [11:0] {
    S_CLR      = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_DEC      = 12'b0000_0000_0100,
    S_LEAF_RD  = 12'b0000_0000_1000,
    S_LEAF_CHK = 12'b0000_0001_0000,
    S_UP_RD    = 12'b0000_0010_0000,
    S_UP_MG    = 12'b0000_0100_0000,
    S_QR_RD    = 12'b0000_1000_0000,
    S_QR_CHK   = 12'b0001_0000_0000,
    S_Q_RD     = 12'b0010_0000_0000,
    S_Q_EV     = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   report_r, report_nxt;

  always_comb begin
    state_nxt   = state_r;
    report_nxt  = report_r;
    cmd.op      = OP_NONE;
    cmd.rd_kids = 1'b0;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_SWEEP;
        if (stat.sweep_last) begin
          state_nxt = report_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_clear) begin
          cmd.op     = OP_SWEEP_INIT;
          report_nxt = 1'b1;
          state_nxt  = S_CLR;
        end else if (stat.is_query) begin
          if (stat.k_zero) begin
            cmd.op    = OP_ANS_ONE;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_ROOT_ADDR;
            state_nxt = S_QR_RD;
          end
        end else if (!stat.in_range) begin
          cmd.op    = OP_RANGE_ERR;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_LEAF_ADDR;
          state_nxt = S_LEAF_RD;
        end
      end
      S_LEAF_RD: state_nxt = S_LEAF_CHK;
      S_LEAF_CHK: begin
        if (stat.leaf_conflict) begin
          cmd.op    = OP_DUP;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_LEAF_WR;
          state_nxt = S_UP_RD;
        end
      end
      S_UP_RD: begin
        cmd.rd_kids = 1'b1;
        state_nxt   = S_UP_MG;
      end
      S_UP_MG: begin
        cmd.op    = OP_MERGE;
        state_nxt = stat.at_root ? S_DONE : S_UP_RD;
      end
      S_QR_RD: state_nxt = S_QR_CHK;
      S_QR_CHK: begin
        if (stat.root_short) begin
          cmd.op    = OP_ROOT_SHORT;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_Q_START;
          state_nxt = S_Q_RD;
        end
      end
      S_Q_RD: begin
        cmd.rd_kids = 1'b1;
        state_nxt   = S_Q_EV;
      end
      S_Q_EV: begin
        cmd.op = OP_DESCEND;
        if ((stat.cross_fit && !stat.left_fit) || stat.half_one) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_Q_RD;
        end
      end
      S_DONE: begin
        report_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      report_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      report_r <= report_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = (state_r == S_DONE);

endmodule

// File: sv/ffs_checker.sv
`include "assert_macros.svh"

module ffs_checker import ffs_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [ANS_W-1:0] out_answer,
  input logic [STS_W-1:0] out_status
);

  // an accepted beat keeps the unit busy until its result
  `CHK_NEXT(a_accept_busy, start && !busy, busy)
  `CHK_NEXT(a_result_frees, out_valid, !busy && !out_valid)
  `CHK_NOW(a_idle_quiet, !busy, !out_valid)
  `CHK_NOW(a_status_code, out_valid, out_status != 2'd3)
  `CHK_NOW(a_flag_no_answer, out_valid && out_status != STS_DONE, out_answer == '0)

endmodule

bind first_fit_free_run_set_unit ffs_checker u_ffs_checker (.*);
